[src/sqlcls_pkg.sv]
`default_nettype none

package sqlcls_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SQUOTE = 3'd1,
    MODE_DQUOTE = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_BLOCK  = 3'd4
  } mode_t;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // one output transaction
  typedef struct packed {
    logic [7:0] chr;
    logic       present;
    logic       last;
  } res_t;

  // one queue entry: up to two results, from the held byte and the final byte
  typedef struct packed {
    logic            pair;
    res_t [1:0]      res;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  typedef struct packed {
    mode_t mode;
    logic  held_valid;
  } front_st_t;

  typedef struct packed {
    mode_t      mode;
    logic       emit;
    logic [7:0] val;
    logic       used;
  } scan_t;

  function automatic scan_t scan_byte(mode_t mode, logic [7:0] ch, logic has_next,
                                      logic [7:0] nxt);
    scan_t r;
    mode_t m;
    m = (mode > MODE_BLOCK) ? MODE_NORMAL : mode;
    r.mode = m;
    r.emit = 1'b0;
    r.val  = 8'h00;
    r.used = 1'b0;
    if (m == MODE_LINE) begin
      if (ch == CH_NL) begin
        r.mode = MODE_NORMAL;
        r.emit = 1'b1;
        r.val  = CH_SPACE;
      end
    end else if (m == MODE_BLOCK) begin
      if (has_next && ch == CH_STAR && nxt == CH_SLASH) begin
        r.mode = MODE_NORMAL;
        r.used = 1'b1;
      end
    end else if (m == MODE_NORMAL && has_next && ch == CH_DASH && nxt == CH_DASH) begin
      r.mode = MODE_LINE;
      r.used = 1'b1;
    end else if (m == MODE_NORMAL && has_next && ch == CH_SLASH && nxt == CH_STAR) begin
      r.mode = MODE_BLOCK;
      r.used = 1'b1;
    end else begin
      r.emit = 1'b1;
      if (m != MODE_DQUOTE && ch == CH_SQ) begin
        r.mode = (m == MODE_SQUOTE) ? MODE_NORMAL : MODE_SQUOTE;
        r.val  = CH_SPACE;
      end else if (m != MODE_SQUOTE && ch == CH_DQ) begin
        r.mode = (m == MODE_DQUOTE) ? MODE_NORMAL : MODE_DQUOTE;
        r.val  = CH_SPACE;
      end else if (m == MODE_SQUOTE || m == MODE_DQUOTE) begin
        r.val = CH_SPACE;
      end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
        r.val = ch + CASE_OFS;
      end else begin
        r.val = ch;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/sqlcls_front.sv]
`default_nettype none

module sqlcls_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_char,
  input  wire logic                  in_last,
  input  wire logic                  q_full,
  output sqlcls_pkg::push_t          push,
  output sqlcls_pkg::front_st_t      st
);

  sqlcls_pkg::mode_t mode, mode_next, mode_mid;
  logic [7:0]        held_byte, held_byte_next;
  logic              held_valid, held_valid_next;
  sqlcls_pkg::scan_t s1, s2;
  logic              accept, emit1, emit2, have_c;
  sqlcls_pkg::entry_t entry;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // held byte sees the new byte as lookahead
    s1       = sqlcls_pkg::scan_byte(mode, held_byte, 1'b1, in_char);
    emit1    = held_valid && s1.emit;
    have_c   = !(held_valid && s1.used);
    mode_mid = held_valid ? s1.mode : mode;
    // final byte is flushed with no lookahead
    s2       = sqlcls_pkg::scan_byte(mode_mid, in_char, 1'b0, 8'h00);
    emit2    = in_last && have_c && s2.emit;

    entry = '0;
    entry.pair = emit1 && emit2;
    if (emit1) begin
      entry.res[0].chr     = s1.val;
      entry.res[0].present = 1'b1;
      entry.res[1].chr     = s2.val;
      entry.res[1].present = 1'b1;
    end else begin
      // end marker carries a zero byte
      entry.res[0].chr     = emit2 ? s2.val : 8'h00;
      entry.res[0].present = emit2;
    end
    if (entry.pair) begin
      entry.res[1].last = in_last;
    end else begin
      entry.res[0].last = in_last;
    end

    push.valid = accept && (emit1 || emit2 || in_last);
    push.entry = entry;

    if (in_last) begin
      mode_next       = sqlcls_pkg::MODE_NORMAL;
      held_byte_next  = 8'h00;
      held_valid_next = 1'b0;
    end else begin
      mode_next       = mode_mid;
      held_byte_next  = have_c ? in_char : 8'h00;
      held_valid_next = have_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= sqlcls_pkg::MODE_NORMAL;
      held_byte  <= 8'h00;
      held_valid <= 1'b0;
    end else if (accept) begin
      mode       <= mode_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
    end
  end

  assign st = '{mode: mode, held_valid: held_valid};

endmodule

`default_nettype wire

[src/sqlcls_back.sv]
`default_nettype none

module sqlcls_back #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sqlcls_pkg::push_t push,
  output logic                   q_full,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_char,
  output logic                   out_present,
  output logic                   out_last
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  sqlcls_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               sel;
  logic               load, pop, do_push;
  sqlcls_pkg::entry_t head;
  sqlcls_pkg::res_t   pick;

  assign q_full  = (count == CNT_FULL);
  assign do_push = push.valid && !q_full;
  assign head    = mem[rd_ptr];
  assign load    = (count != '0) && (!out_valid || out_ready);
  // second half of a pair still pending keeps the entry at the head
  assign pop     = load && (sel || !head.pair);
  assign pick    = sel ? head.res[1] : head.res[0];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push.entry;
    end
    if (load) begin
      out_char    <= pick.chr;
      out_present <= pick.present;
      out_last    <= pick.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      count     <= '0;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(do_push) - CNT_W'(pop);
      if (load) begin
        sel <= !pop;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[src/sql_comment_literal_stripper_top.sv]
// path: a result passes through the queue and then the output register;
// each byte waits in the hold register for the next byte, the final byte flushes
// throughput: one input byte per cycle unless q_full; the scan is combinational;
// one result per cycle on the output when out_ready; the final transaction may
// yield two, sent in turn; the QUEUE_DEPTH-entry queue joins front and back
// reset: synchronous, clears scan mode, hold register, queue and output valid
`default_nettype none

module sql_comment_literal_stripper_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_char,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            out_present,
  output logic            out_last
);

  sqlcls_pkg::push_t     push;
  sqlcls_pkg::front_st_t front_st;
  logic                  q_full;

  sqlcls_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_char  (in_char),
    .in_last  (in_last),
    .q_full   (q_full),
    .push     (push),
    .st       (front_st)
  );

  sqlcls_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .q_full      (q_full),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_present (out_present),
    .out_last    (out_last)
  );

  // scan state never reaches into the next statement
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=>
      (front_st.mode == sqlcls_pkg::MODE_NORMAL && !front_st.held_valid))
    else $error("scan state not cleared after final byte");

  // marker-only transaction is always the final one and carries a zero byte
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_present) |-> (out_last && out_char == 8'h00))
    else $error("bad end marker");

  a_lowercase: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_present) |->
      !(out_char >= sqlcls_pkg::CH_UP_A && out_char <= sqlcls_pkg::CH_UP_Z))
    else $error("uppercase byte on output");

endmodule

`default_nettype wire
